// ===== rtl/pbma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbma_pkg
// Shared constants and types for the point bounding-box moving average core.
// ----------------------------------------------------------------------------
package pbma_pkg;

    localparam int MAX_WINDOW_DEF = 16;
    localparam int COORD_W        = 32;
    localparam int NUM_COORD      = 4;
    localparam int WLEN_W         = 5;

    localparam logic [WLEN_W-1:0] WINDOW_RESET = WLEN_W'(5);

    localparam logic signed [COORD_W-1:0] COORD_POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_LOAD,
        ST_WAIT
    } state_t;

endpackage

// ===== rtl/pbma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pbma_ram #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== rtl/pbma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbma_div
// Four-lane bit-serial restoring divider: unsigned dividends, shared divisor.
// ----------------------------------------------------------------------------
module pbma_div #(
    parameter int SUM_W = 36,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend [pbma_pkg::NUM_COORD],
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output logic [SUM_W-1:0] quotient [pbma_pkg::NUM_COORD]
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_reg  [pbma_pkg::NUM_COORD];
    logic [SUM_W-1:0]  quo_reg  [pbma_pkg::NUM_COORD];
    logic [CNT_W-1:0]  rem_next [pbma_pkg::NUM_COORD];
    logic [SUM_W-1:0]  quo_next [pbma_pkg::NUM_COORD];
    logic [CNT_W:0]    trial    [pbma_pkg::NUM_COORD];

    always_comb
    begin
        for (int j = 0; j < pbma_pkg::NUM_COORD; j++)
        begin
            trial[j] = {rem_reg[j], quo_reg[j][SUM_W-1]};
            if (trial[j] >= {1'b0, div_reg})
            begin
                rem_next[j] = CNT_W'(trial[j] - {1'b0, div_reg});
                quo_next[j] = {quo_reg[j][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = trial[j][CNT_W-1:0];
                quo_next[j] = {quo_reg[j][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            for (int j = 0; j < pbma_pkg::NUM_COORD; j++)
            begin
                rem_reg[j] <= '0;
                quo_reg[j] <= dividend[j];
            end
        end
        else if (busy_reg)
        begin
            for (int j = 0; j < pbma_pkg::NUM_COORD; j++)
            begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/point_bbox_moving_average_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_bbox_moving_average_core
// Per-frame bounding box of valid points, averaged over the last boxes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata {y, x}, tuser valid, tlast end
//  m_axis    out  m_axis_tvalid/tready      tdata {max_y, max_x, min_y, min_x}
//  cfg       in   cfg_wr_en                 cfg_wr_data window_len
//
//  A point without frame end, or ending an empty frame, is taken while idle.
//  A frame end with points steps through ST_SUB, ST_ADD, ST_LOAD and ST_WAIT,
//  which waits on the bit-serial divider; the history ring is read and written once.
//  The result waits in an output register; points keep flowing meanwhile.
//  Reset needs no clearing pass: only pushed ring entries are ever used.
// ----------------------------------------------------------------------------
module point_bbox_moving_average_core #(
    parameter int MAX_WINDOW = pbma_pkg::MAX_WINDOW_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,  // point_x, point_y
    input  logic                        s_axis_tuser,  // point_valid
    input  logic                        s_axis_tlast,  // frame_end
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [127:0]                m_axis_tdata,  // mean_min_x, mean_min_y,
                                                       // mean_max_x, mean_max_y
    input  logic                        cfg_wr_en,
    input  logic [pbma_pkg::WLEN_W-1:0] cfg_wr_data    // window_len
);

    localparam int CW     = pbma_pkg::COORD_W;
    localparam int NC     = pbma_pkg::NUM_COORD;
    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = CW + $clog2(MAX_WINDOW);
    localparam int CMP_W  = (CNT_W > pbma_pkg::WLEN_W) ? CNT_W : pbma_pkg::WLEN_W;
    localparam logic [CNT_W:0]   MAX_EXT  = (CNT_W + 1)'(MAX_WINDOW);
    localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOW - 1);

    pbma_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic signed [CW-1:0] min_x_upd, min_y_upd, max_x_upd, max_y_upd;
    logic                 has_point_reg, has_upd;
    logic signed [CW-1:0] box_reg [NC];
    logic                 evict_reg;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg [NC];
    logic signed [SUM_W-1:0] sum_next [NC];
    logic [pbma_pkg::WLEN_W-1:0] wlen_reg;
    logic [CW-1:0]        out_reg [NC];
    logic                 out_valid_reg;

    logic signed [CW-1:0] px, py;
    logic                 in_acc, push, out_load, div_start, div_busy, mem_we;
    logic [CMP_W-1:0]     wlen_cmp;
    logic [CNT_W-1:0]     eff_len;
    logic [CNT_W:0]       old_sum;
    logic [IDX_W-1:0]     old_idx;
    logic [NC*CW-1:0]     mem_wdata, mem_rdata;
    logic [SUM_W-1:0]     dividend [NC];
    logic [SUM_W-1:0]     quotient [NC];

    assign px     = s_axis_tdata[31:0];
    assign py     = s_axis_tdata[63:32];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        min_x_upd = (s_axis_tuser && px < min_x_reg) ? px : min_x_reg;
        max_x_upd = (s_axis_tuser && px > max_x_reg) ? px : max_x_reg;
        min_y_upd = (s_axis_tuser && py < min_y_reg) ? py : min_y_reg;
        max_y_upd = (s_axis_tuser && py > max_y_reg) ? py : max_y_reg;
        has_upd   = has_point_reg || s_axis_tuser;
        push      = in_acc && s_axis_tlast && has_upd;
    end

    always_comb
    begin
        wlen_cmp = CMP_W'(wlen_reg);
        if (wlen_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (wlen_cmp > MAX_CMP)
        begin
            eff_len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = CNT_W'(wlen_cmp);
        end
        old_sum = (CNT_W + 1)'(head_reg) + MAX_EXT - (CNT_W + 1)'(count_reg);
        if (old_sum >= MAX_EXT)
        begin
            old_sum = old_sum - MAX_EXT;
        end
        old_idx = old_sum[IDX_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbma_pkg::ST_IDLE: if (push) state_next = pbma_pkg::ST_SUB;
            pbma_pkg::ST_SUB:  state_next = pbma_pkg::ST_ADD;
            pbma_pkg::ST_ADD:  state_next = pbma_pkg::ST_LOAD;
            pbma_pkg::ST_LOAD: state_next = pbma_pkg::ST_WAIT;
            pbma_pkg::ST_WAIT: if (out_load) state_next = pbma_pkg::ST_IDLE;
            default:           state_next = pbma_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == pbma_pkg::ST_IDLE);
        mem_we        = (state_reg == pbma_pkg::ST_SUB);
        div_start     = (state_reg == pbma_pkg::ST_LOAD);
        out_load      = (state_reg == pbma_pkg::ST_WAIT) && !div_busy &&
                        (!out_valid_reg || m_axis_tready);
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (cfg_wr_en)
        begin
            head_next  = '0;
            count_next = '0;
            for (int j = 0; j < NC; j++)
            begin
                sum_next[j] = '0;
            end
        end
        else if (state_reg == pbma_pkg::ST_SUB)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
            if (evict_reg)
            begin
                for (int j = 0; j < NC; j++)
                begin
                    sum_next[j] = sum_reg[j] -
                                  SUM_W'($signed(mem_rdata[j*CW +: CW]));
                end
            end
        end
        else if (state_reg == pbma_pkg::ST_ADD)
        begin
            count_next = evict_reg ? count_reg : count_reg + CNT_W'(1);
            for (int j = 0; j < NC; j++)
            begin
                sum_next[j] = sum_reg[j] + SUM_W'(box_reg[j]);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NC; j++)
        begin
            mem_wdata[j*CW +: CW] = box_reg[j];
            dividend[j] = sum_reg[j][SUM_W-1] ? SUM_W'(-sum_reg[j]) : SUM_W'(sum_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbma_pkg::ST_IDLE;
            min_x_reg     <= pbma_pkg::COORD_POS_MAX;
            min_y_reg     <= pbma_pkg::COORD_POS_MAX;
            max_x_reg     <= pbma_pkg::COORD_NEG_MAX;
            max_y_reg     <= pbma_pkg::COORD_NEG_MAX;
            has_point_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            for (int j = 0; j < NC; j++)
            begin
                sum_reg[j] <= '0;
            end
            wlen_reg      <= pbma_pkg::WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (cfg_wr_en)
            begin
                wlen_reg <= cfg_wr_data;
            end
            if (in_acc)
            begin
                if (s_axis_tlast)
                begin
                    min_x_reg     <= pbma_pkg::COORD_POS_MAX;
                    min_y_reg     <= pbma_pkg::COORD_POS_MAX;
                    max_x_reg     <= pbma_pkg::COORD_NEG_MAX;
                    max_y_reg     <= pbma_pkg::COORD_NEG_MAX;
                    has_point_reg <= 1'b0;
                end
                else
                begin
                    min_x_reg     <= min_x_upd;
                    min_y_reg     <= min_y_upd;
                    max_x_reg     <= max_x_upd;
                    max_y_reg     <= max_y_upd;
                    has_point_reg <= has_upd;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            box_reg[0] <= min_x_upd;
            box_reg[1] <= min_y_upd;
            box_reg[2] <= max_x_upd;
            box_reg[3] <= max_y_upd;
            evict_reg  <= (count_reg >= eff_len);
        end
        if (out_load)
        begin
            for (int j = 0; j < NC; j++)
            begin
                out_reg[j] <= sum_reg[j][SUM_W-1] ? CW'(0) - quotient[j][CW-1:0]
                                                  : quotient[j][CW-1:0];
            end
        end
    end

    pbma_ram #(
        .WIDTH (NC * CW),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (head_reg),
        .wdata (mem_wdata),
        .re    (push),
        .raddr (old_idx),
        .rdata (mem_rdata)
    );

    pbma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_WINDOW))
        else $error("history count above ring depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_IDX)
        else $error("history head outside ring");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == pbma_pkg::ST_WAIT))
        else $error("result raised outside divide completion");

endmodule
